// ----- rtl/rgbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbf_pkg
// Shared widths, register indexes, codes and queue word types for the
// rgb555 fade-to-color block.
// ----------------------------------------------------------------------------
package rgbf_pkg;

	// pixel and register widths
	localparam int PIX_W      = 16;
	localparam int TGT_W      = 8;
	localparam int STEP_W     = 10;
	localparam int FPIX_W     = 10;
	localparam int WEIGHT_W   = 13;
	localparam int FRAC_BITS  = 12;
	localparam int PROD_W     = 21;
	localparam int CH_SHIFT   = 15;
	localparam int CH_W       = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd4;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_COUNT_RST   = 10'd1;
	localparam logic [FPIX_W-1:0] FRAME_PIXELS_RST = 10'd512;

	// full blend weight, reached only in the last frame of a fade
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 13'h1000;

	// divider: one quotient bit per cycle
	localparam int DIV_STEPS = 13;

	// default sizes
	localparam int MAX_FRAME_PIXELS_DEF = 512;
	localparam int QUEUE_DEPTH_DEF      = 2;

	// what the back end does with a word
	typedef enum logic [1:0] {
		PIX_CLEAR,
		PIX_SOLID,
		PIX_BLEND
	} pix_kind_t;

	typedef enum logic {
		F_RUN,
		F_DIV
	} front_state_t;

	typedef struct packed {
		pix_kind_t             kind;
		logic [PIX_W-1:0]      pixel;
		logic [WEIGHT_W-1:0]   weight;
		logic                  frame_end;
		logic                  fade_end;
	} queue_word_t;

	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   numer;
		logic [STEP_W-1:0]   denom;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [WEIGHT_W-1:0]   quot;
	} div_rsp_t;

	// classify one pixel against the frame weight
	function automatic queue_word_t make_word(
		input logic [PIX_W-1:0]    pixel,
		input logic [WEIGHT_W-1:0] weight,
		input logic                fend
	);
		queue_word_t w;
		logic        last_frame;
		last_frame = (weight == WEIGHT_ONE);
		w.pixel     = pixel;
		w.weight    = weight;
		w.frame_end = fend;
		w.fade_end  = fend && last_frame;
		if (pixel == '0) begin
			w.kind = PIX_CLEAR;
		end else if (last_frame) begin
			w.kind = PIX_SOLID;
		end else begin
			w.kind = PIX_BLEND;
		end
		return w;
	endfunction

endpackage

// ----- rtl/rgbf_div.sv -----
// ----------------------------------------------------------------------------
// rgbf_div
// Restoring divider for the frame weight: (numer << 12) / denom, numer not
// above denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgbf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rgbf_pkg::div_req_t req,
	output rgbf_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(rgbf_pkg::DIV_STEPS + 1);

	logic [CNT_W-1:0]                   cnt_q;
	logic                               done_q;
	logic [rgbf_pkg::STEP_W:0]          rem_q;
	logic [rgbf_pkg::STEP_W-1:0]        denom_q;
	logic [rgbf_pkg::WEIGHT_W-1:0]      quot_q;

	logic                               fits;
	logic [rgbf_pkg::STEP_W:0]          rem_sub;

	assign fits    = rem_q >= {1'b0, denom_q};
	assign rem_sub = fits ? (rem_q - {1'b0, denom_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(rgbf_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= {1'b0, req.numer};
			denom_q <= req.denom;
			quot_q  <= '0;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the shift fits
			rem_q  <= {rem_sub[rgbf_pkg::STEP_W-1:0], 1'b0};
			quot_q <= {quot_q[rgbf_pkg::WEIGHT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- rtl/rgbf_front.sv -----
// ----------------------------------------------------------------------------
// rgbf_front
// Input side: pixel and frame counters, frame weight via the divider,
// classification of each pixel into a queue word.
// ----------------------------------------------------------------------------
module rgbf_front #(
	parameter int MAX_FRAME_PIXELS = rgbf_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rgbf_pkg::PIX_W-1:0]    pixel_in,
	input  logic [rgbf_pkg::STEP_W-1:0]   step_count,
	input  logic [rgbf_pkg::FPIX_W-1:0]   frame_pixels,
	input  logic                          queue_full,
	output logic                          push,
	output rgbf_pkg::queue_word_t         push_word,
	output rgbf_pkg::div_req_t            div_req,
	input  rgbf_pkg::div_rsp_t            div_rsp
);

	localparam int IDX_W = $clog2(MAX_FRAME_PIXELS);
	localparam int NPX_W = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int CMP_W = (NPX_W > rgbf_pkg::FPIX_W) ? NPX_W : rgbf_pkg::FPIX_W;

	rgbf_pkg::front_state_t              state_q, state_d;
	logic [IDX_W-1:0]                    pix_idx_q, pix_idx_d;
	logic [rgbf_pkg::STEP_W-1:0]         frm_idx_q, frm_idx_d;
	logic [rgbf_pkg::WEIGHT_W-1:0]       weight_q, weight_d;
	logic [rgbf_pkg::PIX_W-1:0]          hold_pixel_q, hold_pixel_d;
	logic                                hold_fend_q, hold_fend_d;

	logic [rgbf_pkg::STEP_W-1:0]         steps_eff;
	logic [rgbf_pkg::STEP_W-1:0]         frm_eff;
	logic [CMP_W-1:0]                    fpix_ext;
	logic [CMP_W-1:0]                    npix;
	logic                                fend;
	logic                                frame_start;

	// clamp the frame size and find the frame end
	always_comb begin
		fpix_ext = CMP_W'(frame_pixels);
		if (fpix_ext == '0) begin
			npix = CMP_W'(1);
		end else if (fpix_ext > CMP_W'(MAX_FRAME_PIXELS)) begin
			npix = CMP_W'(MAX_FRAME_PIXELS);
		end else begin
			npix = fpix_ext;
		end
		fend = (CMP_W'(pix_idx_q) + CMP_W'(1)) >= npix;
	end

	assign steps_eff   = (step_count == '0) ? rgbf_pkg::STEP_W'(1) : step_count;
	assign frm_eff     = (frm_idx_q >= steps_eff) ? '0 : frm_idx_q;
	assign frame_start = (pix_idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rgbf_pkg::F_RUN;
			pix_idx_q <= '0;
			frm_idx_q <= '0;
			weight_q  <= rgbf_pkg::WEIGHT_ONE;
		end else begin
			state_q   <= state_d;
			pix_idx_q <= pix_idx_d;
			frm_idx_q <= frm_idx_d;
			weight_q  <= weight_d;
		end
	end

	always_ff @(posedge clk) begin
		hold_pixel_q <= hold_pixel_d;
		hold_fend_q  <= hold_fend_d;
	end

	always_comb begin
		state_d      = state_q;
		pix_idx_d    = pix_idx_q;
		frm_idx_d    = frm_idx_q;
		weight_d     = weight_q;
		hold_pixel_d = hold_pixel_q;
		hold_fend_d  = hold_fend_q;
		in_stall     = 1'b1;
		push         = 1'b0;
		push_word    = '0;
		div_req      = '0;
		unique case (state_q)
			rgbf_pkg::F_RUN: begin
				in_stall = queue_full;
				if (in_valid && !queue_full) begin
					pix_idx_d = fend ? '0 : pix_idx_q + 1'b1;
					if (frame_start) begin
						// new frame: wrap the frame count, then work out the weight
						frm_idx_d     = frm_eff;
						hold_pixel_d  = pixel_in;
						hold_fend_d   = fend;
						div_req.start = 1'b1;
						div_req.numer = frm_eff + 1'b1;
						div_req.denom = steps_eff;
						state_d       = rgbf_pkg::F_DIV;
					end else begin
						push      = 1'b1;
						push_word = rgbf_pkg::make_word(pixel_in, weight_q, fend);
						if (fend) begin
							frm_idx_d = (weight_q == rgbf_pkg::WEIGHT_ONE) ? '0
								: frm_idx_q + 1'b1;
						end
					end
				end
			end
			rgbf_pkg::F_DIV: begin
				// the queue had room when this word was taken and nothing came since
				if (div_rsp.done) begin
					weight_d  = div_rsp.quot;
					push      = 1'b1;
					push_word = rgbf_pkg::make_word(hold_pixel_q, div_rsp.quot,
						hold_fend_q);
					if (hold_fend_q) begin
						frm_idx_d = (div_rsp.quot == rgbf_pkg::WEIGHT_ONE) ? '0
							: frm_idx_q + 1'b1;
					end
					state_d = rgbf_pkg::F_RUN;
				end
			end
			default: begin
				state_d = rgbf_pkg::F_RUN;
			end
		endcase
	end

endmodule

// ----- rtl/rgbf_queue.sv -----
// ----------------------------------------------------------------------------
// rgbf_queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module rgbf_queue #(
	parameter int DEPTH = rgbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rgbf_pkg::queue_word_t  push_word,
	input  logic                   pop,
	output rgbf_pkg::queue_word_t  pop_word,
	output logic                   full,
	output logic                   empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rgbf_pkg::queue_word_t   mem_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ----- rtl/rgbf_back.sv -----
// ----------------------------------------------------------------------------
// rgbf_back
// Output side: per-channel products, then sum, repack and output register.
// ----------------------------------------------------------------------------
module rgbf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          queue_empty,
	input  rgbf_pkg::queue_word_t         queue_word,
	output logic                          pop,
	input  logic [rgbf_pkg::TGT_W-1:0]    target_red,
	input  logic [rgbf_pkg::TGT_W-1:0]    target_green,
	input  logic [rgbf_pkg::TGT_W-1:0]    target_blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rgbf_pkg::PIX_W-1:0]    pixel_out,
	output logic                          frame_end,
	output logic                          fade_end
);

	localparam int P = rgbf_pkg::PROD_W;

	logic                                 s1_valid_q;
	rgbf_pkg::pix_kind_t                  kind_s1;
	logic                                 mask_s1;
	logic                                 fend_s1;
	logic                                 dend_s1;
	logic [2:0][P-1:0]                    src_prod_s1;
	logic [2:0][P-1:0]                    tgt_prod_s1;

	logic                                 out_valid_q;
	logic [rgbf_pkg::PIX_W-1:0]           pixel_out_q;
	logic                                 frame_end_q;
	logic                                 fade_end_q;

	logic                                 s1_ready;
	logic                                 s2_ready;
	logic [rgbf_pkg::WEIGHT_W-1:0]        inv_weight;
	logic [2:0][rgbf_pkg::TGT_W-1:0]      src8;
	logic [2:0][rgbf_pkg::TGT_W-1:0]      tgt8;
	logic [2:0][P-1:0]                    chan_sum;
	logic [2:0][rgbf_pkg::CH_W-1:0]       chan;
	logic [rgbf_pkg::PIX_W-1:0]           pixel_next;

	assign s2_ready = !out_valid_q || !out_stall;
	assign s1_ready = !s1_valid_q || s2_ready;
	assign pop      = !queue_empty && s1_ready;

	// widen the 5-bit fields to 8 bits
	assign src8[0] = {queue_word.pixel[4:0],   3'b000};
	assign src8[1] = {queue_word.pixel[9:5],   3'b000};
	assign src8[2] = {queue_word.pixel[14:10], 3'b000};
	assign tgt8[0] = target_red;
	assign tgt8[1] = target_green;
	assign tgt8[2] = target_blue;

	assign inv_weight = rgbf_pkg::WEIGHT_ONE - queue_word.weight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= pop;
			end
			if (s2_ready) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// stage 1: six narrow products
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= queue_word.kind;
			mask_s1 <= queue_word.pixel[rgbf_pkg::PIX_W-1];
			fend_s1 <= queue_word.frame_end;
			dend_s1 <= queue_word.fade_end;
			for (int c = 0; c < 3; c++) begin
				src_prod_s1[c] <= P'(src8[c]) * P'(inv_weight);
				tgt_prod_s1[c] <= P'(tgt8[c]) * P'(queue_word.weight);
			end
		end
	end

	// stage 2: sum, scale down and repack
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan_sum[c] = src_prod_s1[c] + tgt_prod_s1[c];
			chan[c]     = chan_sum[c][rgbf_pkg::CH_SHIFT +: rgbf_pkg::CH_W];
		end
		case (kind_s1)
			rgbf_pkg::PIX_SOLID: begin
				pixel_next = {1'b1, target_blue[7:3], target_green[7:3], target_red[7:3]};
			end
			rgbf_pkg::PIX_BLEND: begin
				pixel_next = {mask_s1, chan[2], chan[1], chan[0]};
			end
			default: begin
				pixel_next = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid_q) begin
			pixel_out_q <= pixel_next;
			frame_end_q <= fend_s1;
			fade_end_q  <= dend_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_end = frame_end_q;
	assign fade_end  = fade_end_q;

endmodule

// ----- rtl/rgb555_fade_to_color.sv -----
// ----------------------------------------------------------------------------
// rgb555_fade_to_color
// Linear fade of an RGB555 pixel stream toward a programmed 8-bit color.
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on in_valid/pixel_in, a word is taken when in_valid is high
//   and in_stall is low; results leave on out_valid/pixel_out with frame_end
//   and fade_end, a word is taken when out_valid is high and out_stall is low
//   registers are written through cfg_we/cfg_idx/cfg_data while the block is
//   idle; target color and frame size act at once, step count at the next
//   frame start
// path:
//   an ordinary pixel passes the queue, the stage-1 product register and the
//   output register; the first pixel of each frame also waits for the frame
//   weight from a 13-step restoring divider (one quotient bit per cycle)
//   one pixel per cycle within a frame while the queue has room; the first
//   pixel of a frame holds the input until the divider has the frame weight
// reset:
//   counters to zero, weight to full, step count 1, frame size 512, target 0
// stall:
//   a stalled output holds its word; the back end fills, then the short
//   queue, then in_stall rises
// ----------------------------------------------------------------------------
module rgb555_fade_to_color #(
	parameter int MAX_FRAME_PIXELS = rgbf_pkg::MAX_FRAME_PIXELS_DEF,
	parameter int QUEUE_DEPTH      = rgbf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [rgbf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rgbf_pkg::CFG_DATA_W-1:0]   cfg_data,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rgbf_pkg::PIX_W-1:0]        pixel_in,
	// pixel output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rgbf_pkg::PIX_W-1:0]        pixel_out,
	output logic                              frame_end,
	output logic                              fade_end
);

	// configuration registers
	logic [rgbf_pkg::TGT_W-1:0]    target_red_q;
	logic [rgbf_pkg::TGT_W-1:0]    target_green_q;
	logic [rgbf_pkg::TGT_W-1:0]    target_blue_q;
	logic [rgbf_pkg::STEP_W-1:0]   step_count_q;
	logic [rgbf_pkg::FPIX_W-1:0]   frame_pixels_q;

	// front to queue
	logic                          push;
	rgbf_pkg::queue_word_t         push_word;
	logic                          queue_full;
	// queue to back
	logic                          pop;
	rgbf_pkg::queue_word_t         pop_word;
	logic                          queue_empty;
	// front to divider
	rgbf_pkg::div_req_t            div_req;
	rgbf_pkg::div_rsp_t            div_rsp;

	// register writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_red_q   <= '0;
			target_green_q <= '0;
			target_blue_q  <= '0;
			step_count_q   <= rgbf_pkg::STEP_COUNT_RST;
			frame_pixels_q <= rgbf_pkg::FRAME_PIXELS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rgbf_pkg::REG_TARGET_RED:   target_red_q   <= cfg_data[rgbf_pkg::TGT_W-1:0];
				rgbf_pkg::REG_TARGET_GREEN: target_green_q <= cfg_data[rgbf_pkg::TGT_W-1:0];
				rgbf_pkg::REG_TARGET_BLUE:  target_blue_q  <= cfg_data[rgbf_pkg::TGT_W-1:0];
				rgbf_pkg::REG_STEP_COUNT:   step_count_q   <= cfg_data[rgbf_pkg::STEP_W-1:0];
				rgbf_pkg::REG_FRAME_PIXELS: frame_pixels_q <= cfg_data[rgbf_pkg::FPIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// frame weight divider, shared by every frame start
	rgbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// counters and classification
	rgbf_front #(
		.MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_in     (pixel_in),
		.step_count   (step_count_q),
		.frame_pixels (frame_pixels_q),
		.queue_full   (queue_full),
		.push         (push),
		.push_word    (push_word),
		.div_req      (div_req),
		.div_rsp      (div_rsp)
	);

	// decouples the input side from output stalls
	rgbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// blend arithmetic and output register
	rgbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.queue_word   (pop_word),
		.pop          (pop),
		.target_red   (target_red_q),
		.target_green (target_green_q),
		.target_blue  (target_blue_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.frame_end    (frame_end),
		.fade_end     (fade_end)
	);

endmodule
